// ===== rtl/core/sc2a_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2a_pkg: shared definitions for the scancode to ASCII FIFO core
// Key codes, request codes, the three AZERTY translation ROMs and the
// result record that passes from the FIFO to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

  // Default character FIFO depth.
  localparam int unsigned FIFO_DEPTH_DEF = 256;

  // Request type codes.
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Set-1 key codes with special meaning (release bit stripped).
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_OPTION = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] CAPS_LO    = 7'h10;
  localparam logic [6:0] CAPS_HI    = 7'h32;

  // Number of keys covered by the translation ROMs.
  localparam int unsigned KEY_NUM = 55;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_NUM);

  // Letter ranges for the control mapping.
  localparam logic [6:0] LOWER_A = 7'h61;
  localparam logic [6:0] LOWER_Z = 7'h7A;
  localparam logic [6:0] UPPER_A = 7'h41;
  localparam logic [6:0] UPPER_Z = 7'h5A;

  // Saturation value of the reported fill level.
  localparam logic [7:0] FILL_MAX = 8'hFF;

  // Unshifted layer.
  localparam logic [6:0] MAP_PLAIN [KEY_NUM] = '{
    7'h00, 7'h1B, 7'h26, 7'h65, 7'h22, 7'h27, 7'h28, 7'h2D, 7'h65, 7'h5F,
    7'h63, 7'h61, 7'h29, 7'h3D, 7'h08,
    7'h09, 7'h61, 7'h7A, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
    7'h70, 7'h5E, 7'h24, 7'h0A,
    7'h00, 7'h71, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
    7'h6D, 7'h75, 7'h60,
    7'h00, 7'h3C, 7'h77, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h2C, 7'h3B,
    7'h3A, 7'h21, 7'h00
  };

  // Shifted layer.
  localparam logic [6:0] MAP_SHIFT [KEY_NUM] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h64, 7'h2B, 7'h08,
    7'h09, 7'h41, 7'h5A, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
    7'h50, 7'h5E, 7'h2A, 7'h0A,
    7'h00, 7'h51, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
    7'h4D, 7'h25, 7'h4C,
    7'h00, 7'h3E, 7'h57, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h3F, 7'h2E,
    7'h2F, 7'h53, 7'h00
  };

  // Option layer; a zero entry falls back to the plain or shifted layer.
  localparam logic [6:0] MAP_OPTION [KEY_NUM] = '{
    7'h00, 7'h1B, 7'h00, 7'h7E, 7'h23, 7'h7B, 7'h5B, 7'h7C, 7'h60, 7'h5C,
    7'h5E, 7'h40, 7'h5D, 7'h7D, 7'h08,
    7'h09, 7'h61, 7'h41, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
    7'h50, 7'h45, 7'h3C, 7'h0A,
    7'h00, 7'h4F, 7'h49, 7'h64, 7'h66, 7'h63, 7'h49, 7'h49, 7'h49, 7'h4F,
    7'h6D, 7'h55, 7'h00,
    7'h00, 7'h3C, 7'h2C, 7'h7E, 7'h63, 7'h76, 7'h69, 7'h6E, 7'h2E, 7'h3E,
    7'h2F, 7'h70, 7'h00
  };

  // Result flags and fill level of one item.
  typedef struct packed {
    logic       read_valid;
    logic       char_queued;
    logic       char_dropped;
    logic [7:0] fill_level;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sc2a_if.sv =====
// ----------------------------------------------------------------------------
// sc2a_if: channel interfaces of the scancode to ASCII FIFO core
// Request channel and result channel, each with valid/ready flow control.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2a_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] key_code;

  modport source (output valid, output req_type, output key_code, input ready);
  modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

interface sc2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] read_char;
  logic       read_valid;
  logic       char_queued;
  logic       char_dropped;
  logic [7:0] fill_level;

  modport source (output valid, output read_char, output read_valid,
                  output char_queued, output char_dropped, output fill_level,
                  input ready);
  modport sink   (input valid, input read_char, input read_valid,
                  input char_queued, input char_dropped, input fill_level,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sc2a_decode.sv =====
// ----------------------------------------------------------------------------
// sc2a_decode: modifier tracking and scancode translation
// Holds shift, ctrl, option and caps lock, and maps a pressed key through
// the AZERTY ROMs to a 7-bit character (zero when nothing is produced).
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_decode (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] key_code,
  output logic      [6:0] char_out
);

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic option;
    logic caps;
  } mods_t;

  mods_t mods_r;
  mods_t mods_nxt;

  logic                               release_key;
  logic [6:0]                         key;
  logic                               is_shift;
  logic                               is_ctrl;
  logic                               is_option;
  logic                               is_caps;
  logic                               in_rom;
  logic [sc2a_pkg::KEY_IDX_W-1:0]     idx;
  logic                               shift_eff;
  logic [6:0]                         opt_ch;
  logic [6:0]                         base_ch;
  logic                               is_letter;

  // Split the scancode into the release bit and the key number.
  assign release_key = key_code[7];
  assign key         = key_code[6:0];
  assign is_shift    = (key == sc2a_pkg::KEY_LSHIFT) || (key == sc2a_pkg::KEY_RSHIFT);
  assign is_ctrl     = (key == sc2a_pkg::KEY_CTRL);
  assign is_option   = (key == sc2a_pkg::KEY_OPTION);
  assign is_caps     = (key == sc2a_pkg::KEY_CAPS);
  assign in_rom      = (key < 7'(sc2a_pkg::KEY_NUM));
  assign idx         = key[sc2a_pkg::KEY_IDX_W-1:0];

  // Modifier update: shift, ctrl and option follow press and release,
  // caps lock toggles on each press.
  always_comb begin
    mods_nxt = mods_r;
    if (step) begin
      if (is_shift) begin
        mods_nxt.shift = ~release_key;
      end else if (is_ctrl) begin
        mods_nxt.ctrl = ~release_key;
      end else if (is_option) begin
        mods_nxt.option = ~release_key;
      end else if (!release_key && is_caps) begin
        mods_nxt.caps = ~mods_r.caps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= '0;
    end else begin
      mods_r <= mods_nxt;
    end
  end

  // Caps lock inverts shift on the letter rows only.
  assign shift_eff = mods_r.shift ^
                     (mods_r.caps && (key >= sc2a_pkg::CAPS_LO) &&
                      (key <= sc2a_pkg::CAPS_HI));

  // ROM lookups; an out-of-range key is never used and reads as zero.
  assign opt_ch  = in_rom ? sc2a_pkg::MAP_OPTION[idx] : 7'h00;
  assign base_ch = !in_rom   ? 7'h00 :
                   shift_eff ? sc2a_pkg::MAP_SHIFT[idx] : sc2a_pkg::MAP_PLAIN[idx];
  assign is_letter = ((base_ch >= sc2a_pkg::LOWER_A) && (base_ch <= sc2a_pkg::LOWER_Z)) ||
                     ((base_ch >= sc2a_pkg::UPPER_A) && (base_ch <= sc2a_pkg::UPPER_Z));

  // Final character: only a press of a non-modifier key in the ROM range
  // produces one. An option hit bypasses the control mapping.
  always_comb begin
    char_out = 7'h00;
    if (!release_key && !is_shift && !is_ctrl && !is_option && !is_caps && in_rom) begin
      if (mods_r.option && (opt_ch != 7'h00)) begin
        char_out = opt_ch;
      end else if (mods_r.ctrl && is_letter) begin
        char_out = {2'b00, base_ch[4:0]};
      end else begin
        char_out = base_ch;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sc2a_fifo.sv =====
// ----------------------------------------------------------------------------
// sc2a_fifo: character ring buffer
// Single-port-per-side memory with wrap-around pointers and an occupancy
// count; one push or one pop per step, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_fifo #(
  parameter int unsigned FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic          wr_req,
  input  wire logic [6:0]    wr_char,
  input  wire logic          rd_req,
  output sc2a_pkg::res_t     res,
  output logic      [6:0]    rd_char_r
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = (PTR_W > 8) ? PTR_W : 8;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH - 1);

  logic [6:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full;
  logic             empty;
  logic             push;
  logic             pop;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);

  // Grant the request of this beat against the current occupancy.
  assign push = step && wr_req && !full;
  assign pop  = step && rd_req && !empty;

  // Pointer and count update; pointers wrap at the last entry.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt  = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (pop) begin
      rp_nxt  = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Character store. A pop never reads the entry being pushed, since a
  // step is either a push or a pop.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_char;
    end
    if (step) begin
      rd_char_r <= mem[rp_r];
    end
  end

  // Flags of this beat and the saturated occupancy after it.
  always_comb begin
    res.read_valid   = rd_req && !empty;
    res.char_queued  = wr_req && !full;
    res.char_dropped = wr_req && full;
    res.fill_level   = (cnt_nxt > CNT_W'(255)) ? sc2a_pkg::FILL_MAX : cnt_nxt[7:0];
  end

  // Occupancy never passes one less than the depth.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_FULL)
    else $error("FIFO count beyond capacity");

  // The count agrees with the pointers about emptiness.
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == '0) == (wp_r == rp_r))
    else $error("FIFO count and pointers disagree");

  // A granted push raises the count by one.
  assert property (@(posedge clk) disable iff (!rst_n)
                   push |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("FIFO count not raised by push");

endmodule

`default_nettype wire

// ===== rtl/core/scancode_to_ascii_fifo_core.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_core: set-1 scancode decoder with character FIFO
// Input register, translation and FIFO access, result register.
// ----------------------------------------------------------------------------
// The core takes one beat per clock cycle on the request channel while the
// result channel does not stall, either a scancode event or a request to read
// one character, and returns exactly one result beat for each. A request is
// held in the input register, where the modifier state, the translation ROMs
// and the FIFO are evaluated, and its result is loaded into the result
// register once that register is free or its result is taken. Sustained
// throughput is one request per cycle while the result channel is ready, set
// by the single FIFO access (one push or one pop) each request makes. New
// requests are taken while a result waits, until both stages are occupied.
// The character store is not cleared after reset and needs no initialisation
// time.
`default_nettype none

module scancode_to_ascii_fifo_core #(
  parameter int unsigned FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sc2a_in_if.sink    in_ch,
  sc2a_out_if.source out_ch
);

  logic           a_valid_r, a_valid_nxt;
  logic           a_req_r;
  logic [7:0]     a_key_r;
  logic           b_valid_r, b_valid_nxt;
  sc2a_pkg::res_t b_res_r;
  logic           adv;
  logic           in_fire;
  logic           scan_step;
  logic [6:0]     char_w;
  logic [6:0]     rd_char;
  sc2a_pkg::res_t res_w;

  // Stage handshakes.
  assign adv         = a_valid_r && (!b_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign scan_step   = adv && (a_req_r == sc2a_pkg::REQ_SCAN);

  // Input register.
  assign a_valid_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_req_r <= in_ch.req_type;
      a_key_r <= in_ch.key_code;
    end
  end

  // Translation with modifier state.
  sc2a_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (scan_step),
    .key_code (a_key_r),
    .char_out (char_w)
  );

  // Character FIFO.
  sc2a_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .wr_req    ((a_req_r == sc2a_pkg::REQ_SCAN) && (char_w != 7'h00)),
    .wr_char   (char_w),
    .rd_req    (a_req_r == sc2a_pkg::REQ_READ),
    .res       (res_w),
    .rd_char_r (rd_char)
  );

  // Result register.
  assign b_valid_nxt = adv ? 1'b1 : ((b_valid_r && out_ch.ready) ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_res_r <= res_w;
    end
  end

  // Result beat; the read data register holds with the result register.
  assign out_ch.valid        = b_valid_r;
  assign out_ch.read_char    = b_res_r.read_valid ? rd_char : 7'h00;
  assign out_ch.read_valid   = b_res_r.read_valid;
  assign out_ch.char_queued  = b_res_r.char_queued;
  assign out_ch.char_dropped = b_res_r.char_dropped;
  assign out_ch.fill_level   = b_res_r.fill_level;

  // A request that cannot move on stays in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (a_valid_r && !adv) |=> a_valid_r)
    else $error("Input stage lost a held request");

endmodule

`default_nettype wire
